FILE: src/drs_pkg.sv
// drs_pkg: widths, types and sequencer states for the decimal radix sorter
// no dependencies; imported by every other file of the block
package drs_pkg;

  localparam int VAL_W         = 64;
  localparam int NDIG          = 20;
  localparam int BCD_W         = 4 * NDIG;
  localparam int DIG_W         = 5;
  localparam int STEP_W        = 7;
  localparam int RADIX         = 10;
  localparam int DEF_MAX_ITEMS = 64;

  typedef struct packed {
    logic               done;
    logic [BCD_W-1:0]   bcd;
    logic [DIG_W-1:0]   ndig;
  } conv_t;

  typedef struct packed {
    logic [BCD_W-1:0]   bcd;
    logic [VAL_W-1:0]   value;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CONV,
    S_HIST_RD,
    S_HIST_UP,
    S_PRE,
    S_SCAT_RD,
    S_SCAT_WR,
    S_OUT_RD,
    S_OUT
  } state_t;

endpackage

FILE: src/drs_if.sv
// drs_in_if / drs_out_if: valid-ready channels of the decimal radix sorter
// depends on drs_pkg for the payload widths
interface drs_in_if import drs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] value;
  logic             last;
  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface drs_out_if import drs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] sorted_value;
  logic             final_res;
  modport source (output valid, output sorted_value, output final_res, input ready);
  modport sink   (input valid, input sorted_value, input final_res, output ready);
endinterface

FILE: src/drs_bcd.sv
// drs_bcd: shift-and-add-3 binary to decimal converter, one bit per cycle
// depends on drs_pkg; reports the digits and the count of significant digits
module drs_bcd import drs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start_i,
  input  logic [VAL_W-1:0] value_i,
  output conv_t            conv_o
);

  logic [VAL_W-1:0]  bin_r;
  logic [BCD_W-1:0]  bcd_r;
  logic [BCD_W-1:0]  adj;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;
  logic [DIG_W-1:0]  ndig;

  always_comb begin
    for (int k = 0; k < NDIG; k++) begin
      if (bcd_r[4*k +: 4] >= 4'd5) begin
        adj[4*k +: 4] = bcd_r[4*k +: 4] + 4'd3;
      end else begin
        adj[4*k +: 4] = bcd_r[4*k +: 4];
      end
    end
  end

  always_comb begin
    ndig = '0;
    for (int k = 0; k < NDIG; k++) begin
      if (bcd_r[4*k +: 4] != 4'd0) begin
        ndig = DIG_W'(k + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start_i) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + STEP_W'(1);
        if (step_r == STEP_W'(VAL_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      bin_r <= value_i;
      bcd_r <= '0;
    end else if (busy_r) begin
      bcd_r <= {adj[BCD_W-2:0], bin_r[VAL_W-1]};
      bin_r <= {bin_r[VAL_W-2:0], 1'b0};
    end
  end

  assign conv_o.done = done_r;
  assign conv_o.bcd  = bcd_r;
  assign conv_o.ndig = ndig;

endmodule

FILE: src/drs_sort.sv
// drs_sort: sequencer, two-bank entry store and digit histogram of the sorter
// depends on drs_pkg, drs_if and the converter result from drs_bcd
module drs_sort import drs_pkg::*; #(
  parameter int MAX_ITEMS = DEF_MAX_ITEMS
) (
  input  logic             clk,
  input  logic             rst_n,
  drs_in_if.sink           in_ch,
  drs_out_if.source        out_ch,
  output logic             conv_start_o,
  output logic [VAL_W-1:0] conv_value_o,
  input  conv_t            conv_i
);

  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW = $clog2(MAX_ITEMS + 1);

  state_t state_r, state_nxt;

  entry_t         mem_r [2][MAX_ITEMS];
  entry_t         rdata_r;
  logic           rd_en, rd_bank;
  logic [AW-1:0]  rd_idx;
  logic           wr_en, wr_bank;
  logic [AW-1:0]  wr_idx;
  entry_t         wr_data;

  logic [CW-1:0]  counts_r [RADIX];
  logic [CW-1:0]  counts_nxt [RADIX];
  logic [CW-1:0]  count_r, count_nxt;
  logic [DIG_W-1:0] maxdig_r, maxdig_nxt;
  logic [DIG_W-1:0] pass_r, pass_nxt;
  logic [AW-1:0]  idx_r, idx_nxt;
  logic [3:0]     j_r, j_nxt;
  logic           bank_r, bank_nxt;
  logic           last_r, last_nxt;
  logic [VAL_W-1:0] value_r;
  logic [3:0]     dig;
  logic [CW-1:0]  pos;
  logic [DIG_W-1:0] newdig;
  logic           at_end;

  assign dig    = rdata_r.bcd[4*pass_r +: 4];
  assign pos    = counts_r[dig] - CW'(1);
  assign at_end = (CW'(idx_r) + CW'(1)) == count_r;
  assign newdig = (conv_i.ndig > maxdig_r) ? conv_i.ndig : maxdig_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_bank][wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem_r[rd_bank][rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      maxdig_r <= '0;
      pass_r   <= '0;
      idx_r    <= '0;
      j_r      <= '0;
      bank_r   <= 1'b0;
      last_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      maxdig_r <= maxdig_nxt;
      pass_r   <= pass_nxt;
      idx_r    <= idx_nxt;
      j_r      <= j_nxt;
      bank_r   <= bank_nxt;
      last_r   <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    counts_r <= counts_nxt;
    if (in_ch.valid && in_ch.ready) begin
      value_r <= in_ch.value;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    maxdig_nxt   = maxdig_r;
    pass_nxt     = pass_r;
    idx_nxt      = idx_r;
    j_nxt        = j_r;
    bank_nxt     = bank_r;
    last_nxt     = last_r;
    counts_nxt   = counts_r;
    rd_en        = 1'b0;
    rd_bank      = bank_r;
    rd_idx       = idx_r;
    wr_en        = 1'b0;
    wr_bank      = bank_r;
    wr_idx       = count_r[AW-1:0];
    wr_data      = '{bcd: conv_i.bcd, value: value_r};
    conv_start_o = 1'b0;
    conv_value_o = in_ch.value;
    in_ch.ready  = (state_r == S_IDLE);
    out_ch.valid = (state_r == S_OUT);
    out_ch.sorted_value = rdata_r.value;
    out_ch.final_res    = at_end;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          last_nxt = in_ch.last;
          if (count_r < CW'(MAX_ITEMS)) begin
            conv_start_o = 1'b1;
            state_nxt    = S_CONV;
          end else if (in_ch.last) begin
            pass_nxt = '0;
            idx_nxt  = '0;
            for (int k = 0; k < RADIX; k++) counts_nxt[k] = '0;
            state_nxt = (maxdig_r == '0) ? S_OUT_RD : S_HIST_RD;
          end
        end
      end
      S_CONV: begin
        if (conv_i.done) begin
          wr_en      = 1'b1;
          count_nxt  = count_r + CW'(1);
          maxdig_nxt = newdig;
          if (last_r) begin
            pass_nxt = '0;
            idx_nxt  = '0;
            for (int k = 0; k < RADIX; k++) counts_nxt[k] = '0;
            state_nxt = (newdig == '0) ? S_OUT_RD : S_HIST_RD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_HIST_RD: begin
        rd_en     = 1'b1;
        state_nxt = S_HIST_UP;
      end
      S_HIST_UP: begin
        counts_nxt[dig] = counts_r[dig] + CW'(1);
        if (at_end) begin
          j_nxt     = 4'd1;
          state_nxt = S_PRE;
        end else begin
          idx_nxt   = idx_r + AW'(1);
          state_nxt = S_HIST_RD;
        end
      end
      S_PRE: begin
        counts_nxt[j_r] = counts_r[j_r] + counts_r[j_r - 4'd1];
        if (j_r == 4'(RADIX - 1)) begin
          idx_nxt   = AW'(count_r - CW'(1));
          state_nxt = S_SCAT_RD;
        end else begin
          j_nxt = j_r + 4'd1;
        end
      end
      S_SCAT_RD: begin
        rd_en     = 1'b1;
        state_nxt = S_SCAT_WR;
      end
      S_SCAT_WR: begin
        wr_en           = 1'b1;
        wr_bank         = !bank_r;
        wr_idx          = pos[AW-1:0];
        wr_data         = rdata_r;
        counts_nxt[dig] = pos;
        if (idx_r == '0) begin
          bank_nxt = !bank_r;
          pass_nxt = pass_r + DIG_W'(1);
          for (int k = 0; k < RADIX; k++) counts_nxt[k] = '0;
          state_nxt = ((pass_r + DIG_W'(1)) == maxdig_r) ? S_OUT_RD : S_HIST_RD;
        end else begin
          idx_nxt   = idx_r - AW'(1);
          state_nxt = S_SCAT_RD;
        end
      end
      S_OUT_RD: begin
        rd_en     = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ch.ready) begin
          if (at_end) begin
            count_nxt  = '0;
            maxdig_nxt = '0;
            idx_nxt    = '0;
            state_nxt  = S_IDLE;
          end else begin
            idx_nxt   = idx_r + AW'(1);
            state_nxt = S_OUT_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

FILE: src/decimal_radix_sorter.sv
// Decimal radix sorter: collects up to MAX_ITEMS unsigned 64-bit items and,
// on the item marked last, sorts them ascending by base-10 LSD radix sort and
// sends them out in order with the final one marked. Each stored item is
// taken at the input, converted by the bit-serial binary to decimal converter
// and then written to the store; an item that arrives with the store full is
// dropped. Sorting runs one pass per significant decimal digit of the largest
// item, each pass limited by the histogram, updated one digit at a time, and
// by the one read / one write port of the two-bank store. Each output item is
// read from the store and then shown until out_ready takes it. The input is
// not ready while an item is converted and stored, nor from the item marked
// last until its last sorted item is taken.
// depends on drs_pkg, drs_if, drs_bcd and drs_sort
module decimal_radix_sorter import drs_pkg::*; #(
  parameter int MAX_ITEMS = DEF_MAX_ITEMS
) (
  input  logic      clk,
  input  logic      rst_n,
  drs_in_if.sink    in_ch,
  drs_out_if.source out_ch
);

  conv_t            conv;
  logic             conv_start;
  logic [VAL_W-1:0] conv_value;

  drs_bcd u_bcd (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (conv_start),
    .value_i (conv_value),
    .conv_o  (conv)
  );

  drs_sort #(.MAX_ITEMS(MAX_ITEMS)) u_sort (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .conv_start_o (conv_start),
    .conv_value_o (conv_value),
    .conv_i       (conv)
  );

endmodule

FILE: src/drs_checker.sv
// drs_checker: port-level checks of the decimal radix sorter
// depends on drs_pkg; bound to decimal_radix_sorter below
module drs_checker import drs_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             in_last,
  input logic             out_valid,
  input logic             out_ready,
  input logic [VAL_W-1:0] out_value,
  input logic             out_final
);

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while an item is shown");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("item shown right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_final))
    else $error("stalled item changed");

  a_set_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_final |=> !out_valid)
    else $error("item after the final one");

  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("ready right after the last item");

endmodule

bind decimal_radix_sorter drs_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_last   (in_ch.last),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_value (out_ch.sorted_value),
  .out_final (out_ch.final_res)
);

FILE: tb/sv/tb_decimal_radix_sorter.sv
// tb_decimal_radix_sorter: self-checking testbench of the decimal radix sorter
// drives item sets over drs_in_if, checks the sorted stream on drs_out_if
// depends on drs_pkg, drs_if and decimal_radix_sorter
`timescale 1ns / 100ps

module tb_decimal_radix_sorter;
  import drs_pkg::*;

  localparam int STORE_DEPTH = DEF_MAX_ITEMS;
  localparam int STALL_LIMIT = 40000;

  typedef struct {
    logic [VAL_W-1:0] value;
    logic             final_res;
  } sorted_t;

  typedef struct {
    logic [VAL_W-1:0] value;
    logic             last;
    bit               known;
    logic [VAL_W-1:0] known_val;
  } stim_row_t;

  logic clk;
  logic rst_n;

  drs_in_if  in_ch ();
  drs_out_if out_ch ();

  decimal_radix_sorter dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic [VAL_W-1:0] held_vals [STORE_DEPTH];
  int               held_cnt;
  sorted_t          sorted_q [$];
  int               err_cnt;
  int               in_idle_pct;
  int               out_idle_pct;
  int               items_sent;
  int               results_seen;
  int               sets_sent;
  int               quiet_cycles;
  int               directed_idx = -1;

  stim_row_t directed_rows [] = '{
    '{64'd0, 1'b1, 1'b1, 64'd0},
    '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF},
    '{64'd1, 1'b1, 1'b1, 64'd1},
    '{64'd10_000_000_000_000_000_000, 1'b1, 1'b1, 64'd10_000_000_000_000_000_000},
    '{64'd0, 1'b0, 1'b0, 64'd0},
    '{64'd0, 1'b0, 1'b0, 64'd0},
    '{64'd0, 1'b1, 1'b0, 64'd0},
    '{64'd5, 1'b0, 1'b0, 64'd0},
    '{64'd3, 1'b0, 1'b0, 64'd0},
    '{64'd9, 1'b1, 1'b0, 64'd0},
    '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 64'd0},
    '{64'd9_999_999_999_999_999_999, 1'b0, 1'b0, 64'd0},
    '{64'd10_000_000_000_000_000_000, 1'b0, 1'b0, 64'd0},
    '{64'd0, 1'b0, 1'b0, 64'd0},
    '{64'd1, 1'b1, 1'b0, 64'd0},
    '{64'd21, 1'b0, 1'b0, 64'd0},
    '{64'd11, 1'b0, 1'b0, 64'd0},
    '{64'd21, 1'b0, 1'b0, 64'd0},
    '{64'd1, 1'b0, 1'b0, 64'd0},
    '{64'd100, 1'b0, 1'b0, 64'd0},
    '{64'd99, 1'b1, 1'b0, 64'd0}
  };

  function automatic void digit_pass(int n, logic [VAL_W-1:0] place);
    int               cnt [10];
    logic [VAL_W-1:0] tmp [STORE_DEPTH];
    int               d;
    cnt = '{default: 0};
    for (int i = 0; i < n; i++) begin
      d = int'((held_vals[i] / place) % 10);
      cnt[d]++;
    end
    for (int i = 1; i < 10; i++) cnt[i] += cnt[i-1];
    for (int i = n - 1; i >= 0; i--) begin
      d = int'((held_vals[i] / place) % 10);
      cnt[d]--;
      tmp[cnt[d]] = held_vals[i];
    end
    for (int i = 0; i < n; i++) held_vals[i] = tmp[i];
  endfunction

  function automatic void absorb_item(logic [VAL_W-1:0] v, logic lst);
    logic [VAL_W-1:0] largest;
    logic [VAL_W-1:0] place;
    sorted_t          res;
    if (held_cnt < STORE_DEPTH) begin
      held_vals[held_cnt] = v;
      held_cnt++;
    end
    if (!lst) return;
    largest = 0;
    for (int i = 0; i < held_cnt; i++)
      if (held_vals[i] > largest) largest = held_vals[i];
    place = 1;
    while (largest / place > 0) begin
      digit_pass(held_cnt, place);
      if (place > largest / 10) break;
      place = place * 10;
    end
    for (int i = 0; i < held_cnt; i++) begin
      res.value     = held_vals[i];
      res.final_res = (i == held_cnt - 1);
      sorted_q.push_back(res);
    end
    held_cnt = 0;
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    logic [VAL_W-1:0] p;
    case ($urandom_range(3))
      0: return VAL_W'($urandom_range(99));
      1: return {$urandom, $urandom};
      2: begin
        p = 1;
        repeat ($urandom_range(19)) p = p * 10;
        return p - VAL_W'($urandom_range(1));
      end
      default: return {$urandom, $urandom} >> $urandom_range(63);
    endcase
  endfunction

  task automatic send_item(logic [VAL_W-1:0] v, logic lst);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    in_ch.last  <= lst;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (sorted_q.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic send_set(int n);
    logic [VAL_W-1:0] v;
    bit               zeros;
    zeros = ($urandom_range(15) == 0);
    for (int i = 0; i < n; i++) begin
      v = zeros ? '0 : pick_value();
      send_item(v, i == n - 1);
    end
    items_sent += n;
    sets_sent++;
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      if (directed_idx >= 0 && directed_rows[directed_idx].known) begin
        absorb_item(in_ch.value, in_ch.last);
        void'(sorted_q.pop_back());
        sorted_q.push_back('{directed_rows[directed_idx].known_val, 1'b1});
      end else begin
        absorb_item(in_ch.value, in_ch.last);
      end
    end
  end

  always @(posedge clk) begin
    sorted_t exp_res;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (sorted_q.size() == 0) begin
        $error("result with nothing expected: sorted_value %0d", out_ch.sorted_value);
        err_cnt++;
      end else begin
        exp_res = sorted_q.pop_front();
        if (out_ch.sorted_value !== exp_res.value) begin
          $error("sorted_value expected %0d actual %0d", exp_res.value, out_ch.sorted_value);
          err_cnt++;
        end
        if (out_ch.final_res !== exp_res.final_res) begin
          $error("final_res expected %0b actual %0b", exp_res.final_res, out_ch.final_res);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("timeout after %0d cycles without an item", STALL_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int idle_in [3]  = '{12, 63, 0};
    int idle_out [3] = '{63, 12, 0};
    items_sent   = 0;
    sets_sent    = 0;
    in_idle_pct  = 0;
    out_idle_pct = 0;
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.value  <= '0;
    in_ch.last   <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      directed_idx = i;
      send_item(directed_rows[i].value, directed_rows[i].last);
      if (directed_rows[i].known) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
      items_sent++;
    end
    directed_idx = -1;
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      in_idle_pct  = idle_in[ph];
      out_idle_pct = idle_out[ph];
      if (ph == 2) send_set(70);
      while (items_sent < 20 + 80 * (ph + 1))
        send_set(($urandom_range(7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6));
      drain();
    end

    repeat (100) @(posedge clk);
    $display("covered %0d items in %0d sets, %0d sorted results checked,", items_sent,
             sets_sent + 8, results_seen);
    $display("including a full store with dropped items and three idle profiles");
    if (err_cnt == 0 && sorted_q.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
